// ----- src/rnorm_pkg.sv -----
// ----------------------------------------------------------------------------
// rnorm_pkg
// Types and constants shared by the rational normalizer modules: the item
// structs of both channels and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rnorm_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] num_in;
      logic signed [DATA_WIDTH-1:0] den_in;
   } rnorm_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] num_out;
      logic        [DATA_WIDTH-2:0] den_out;
      logic                         undefined_flag;
   } rnorm_rsp_type;

   typedef struct packed {
      logic load;      // capture a new item and start the GCD
      logic gcd_step;  // one binary GCD step
      logic div_init;  // set up a division
      logic sel_den;   // the division set up works on the denominator
      logic div_step;  // one quotient bit
      logic out_load;  // write the result register
   } rnorm_cmd_type;

   typedef struct packed {
      logic both_zero;
      logic gcd_done;
   } rnorm_status_type;

endpackage

// ----- src/rnorm_datapath.sv -----
// ----------------------------------------------------------------------------
// rnorm_datapath
// Magnitude capture, a one-step-per-cycle binary GCD, a restoring divider
// that yields one quotient bit per cycle, and the result register with sign
// and saturation handling.
// ----------------------------------------------------------------------------
module rnorm_datapath
   import rnorm_pkg::*;
(
   input  logic             clock,
   input  rnorm_cmd_type    cmd,
   input  rnorm_req_type    req_data,
   output rnorm_status_type status,
   output rnorm_rsp_type    rsp_data
);

   logic [DATA_WIDTH-1:0] num_raw, den_raw, num_mag, den_mag;

   logic [DATA_WIDTH-1:0] nm_ff, nm_in, dm_ff, dm_in;
   logic                  sdiff_ff, sdiff_in;
   logic                  zz_ff, zz_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [DATA_WIDTH-1:0] g_ff, g_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rn_ff, rn_in;
   rnorm_rsp_type         rsp_ff, rsp_in;

   logic [DATA_WIDTH-1:0] diff_ab, diff_ba;
   logic                  a_ge_b;
   logic [DATA_WIDTH:0]   shifted, trial;
   logic                  neg;
   logic [DATA_WIDTH-1:0] num_mag_out;

   assign num_raw = req_data.num_in;
   assign den_raw = req_data.den_in;
   assign num_mag = num_raw[DATA_WIDTH-1] ? (~num_raw + 1'b1) : num_raw;
   assign den_mag = den_raw[DATA_WIDTH-1] ? (~den_raw + 1'b1) : den_raw;

   assign diff_ab = a_ff - b_ff;
   assign diff_ba = b_ff - a_ff;
   assign a_ge_b  = (a_ff >= b_ff);

   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign trial   = shifted - {1'b0, g_ff};

   always_comb begin
      nm_in    = nm_ff;
      dm_in    = dm_ff;
      sdiff_in = sdiff_ff;
      zz_in    = zz_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      if (cmd.load) begin
         nm_in    = num_mag;
         dm_in    = den_mag;
         sdiff_in = num_raw[DATA_WIDTH-1] ^ den_raw[DATA_WIDTH-1];
         zz_in    = (num_mag == '0) && (den_mag == '0);
         a_in     = num_mag;
         b_in     = den_mag;
         k_in     = '0;
      end else if (cmd.gcd_step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ge_b) begin
            // The difference of two odd values is even, so halve it at once.
            a_in = diff_ab >> 1;
         end else begin
            b_in = diff_ba >> 1;
         end
      end
   end

   always_comb begin
      g_in   = g_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      rn_in  = rn_ff;
      if (cmd.div_init) begin
         rem_in = '0;
         if (cmd.sel_den) begin
            quo_in = dm_ff;
            rn_in  = quo_ff;
         end else begin
            // One of a and b is zero here; the other, shifted left by k, is the GCD.
            g_in   = (a_ff | b_ff) << k_ff;
            quo_in = nm_ff;
         end
      end else if (cmd.div_step) begin
         if (!trial[DATA_WIDTH]) begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
      end
   end

   assign neg         = sdiff_ff && (rn_ff != '0);
   assign num_mag_out = (!neg && rn_ff[DATA_WIDTH-1]) ? MAX_POS : rn_ff;

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         if (zz_ff) begin
            rsp_in.num_out        = '0;
            rsp_in.den_out        = (DATA_WIDTH-1)'(1);
            rsp_in.undefined_flag = 1'b1;
         end else begin
            rsp_in.num_out        = neg ? (~rn_ff + 1'b1) : num_mag_out;
            rsp_in.den_out        = quo_ff[DATA_WIDTH-1] ? MAX_POS[DATA_WIDTH-2:0]
                                                         : quo_ff[DATA_WIDTH-2:0];
            rsp_in.undefined_flag = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      nm_ff    <= nm_in;
      dm_ff    <= dm_in;
      sdiff_ff <= sdiff_in;
      zz_ff    <= zz_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      g_ff     <= g_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      rn_ff    <= rn_in;
      rsp_ff   <= rsp_in;
   end

   assign status.both_zero = zz_ff;
   assign status.gcd_done  = (a_ff == '0) || (b_ff == '0);
   assign rsp_data         = rsp_ff;

endmodule

// ----- src/rnorm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rnorm_ctrl
// Sequencer for the rational normalizer: accepts an item, runs the GCD to
// completion, runs the two divisions (both skipped for zero over zero) and hands
// the result to the output register once it is free.
// ----------------------------------------------------------------------------
module rnorm_ctrl
   import rnorm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  rnorm_status_type status,
   output rnorm_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_GCD  = 6'b000010,
      ST_DIVN = 6'b000100,
      ST_SETD = 6'b001000,
      ST_DIVD = 6'b010000,
      ST_DONE = 6'b100000
   } rnorm_state_type;

   rnorm_state_type  state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free, cnt_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_last = (cnt_ff == CNT_W'(DATA_WIDTH-1));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.both_zero) begin
               state_in = ST_DONE;
            end else if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIVN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIVN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = ST_SETD;
            end
         end
         ST_SETD: begin
            cmd.div_init = 1'b1;
            cmd.sel_den  = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIVD;
         end
         ST_DIVD: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/rational_normalizer.sv -----
// ----------------------------------------------------------------------------
// rational_normalizer
// Reduces a signed fraction to lowest terms with a binary GCD followed by two
// restoring divisions; the sign goes on the numerator.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_stall   req_data (rnorm_req_type)
//   rsp       out         rsp_valid / rsp_stall   rsp_data (rnorm_rsp_type)
//
// An item is captured, then takes one binary GCD step per cycle until one term
// is zero, then runs the two divisions at one quotient bit per cycle each, and
// finally loads the result. Zero over zero skips the GCD and the divisions.
// One item is worked on at a time; the next is taken while a result waits.
// A stalled result holds the sequencer in its last state until the result
// register frees up. Reset clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
module rational_normalizer
   import rnorm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  rnorm_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rnorm_rsp_type rsp_data
);

   rnorm_cmd_type    cmd;
   rnorm_status_type status;

   rnorm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rnorm_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

`ifndef ASSERT_OFF
   // A result waiting on a stalled output is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register loaded while a result was stalled");

   // Once an item is taken the block is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after an accept");

   // Zero over zero always reports 0/1.
   a_undefined_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.undefined_flag) |->
         (rsp_data.num_out == '0) && (rsp_data.den_out == (DATA_WIDTH-1)'(1)))
      else $error("undefined result is not 0/1");

   // A zero denominator only comes with a unit numerator.
   a_zero_den_unit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.undefined_flag && (rsp_data.den_out == '0)) |->
         ((rsp_data.num_out == DATA_WIDTH'(1)) || (rsp_data.num_out == '1)))
      else $error("zero denominator with a numerator other than 1 or -1");
`endif

endmodule

// ----- test/rational_normalizer_checker.sv -----
// ----------------------------------------------------------------------------
// rational_normalizer_checker
// Watches both channels of the rational normalizer. For every accepted request
// it works out the reduced fraction, and it compares each accepted result,
// field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module rational_normalizer_checker
   import rnorm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  rnorm_req_type req_data,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  rnorm_rsp_type rsp_data,
   output int            mismatches,
   output int            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      rnorm_req_type fraction;
      rnorm_rsp_type reduced;
   } fraction_pair_type;

   fraction_pair_type reduced_q[$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // Magnitudes are one bit wider than the data so that the most negative
   // input keeps its exact magnitude.
   function automatic rnorm_rsp_type reduce_fraction(rnorm_req_type fraction);
      logic signed [DATA_WIDTH:0] wide_num, wide_den;
      logic [DATA_WIDTH:0] num_mag, den_mag, a, b, rem, red_num, red_den;
      logic num_neg, den_neg, negative;
      rnorm_rsp_type reduced;
      wide_num = $signed(fraction.num_in);
      wide_den = $signed(fraction.den_in);
      num_neg  = fraction.num_in[DATA_WIDTH-1];
      den_neg  = fraction.den_in[DATA_WIDTH-1];
      num_mag  = num_neg ? -wide_num : wide_num;
      den_mag  = den_neg ? -wide_den : wide_den;
      if (num_mag == 0 && den_mag == 0) begin
         reduced.num_out        = '0;
         reduced.den_out        = (DATA_WIDTH-1)'(1);
         reduced.undefined_flag = 1'b1;
         return reduced;
      end
      a = num_mag;
      b = den_mag;
      while (b != 0) begin
         rem = a % b;
         a   = b;
         b   = rem;
      end
      red_num  = num_mag / a;
      red_den  = den_mag / a;
      negative = (num_neg != den_neg) && red_num != 0;
      // A positive numerator or a denominator of 2^(DATA_WIDTH-1) saturates.
      if (!negative && red_num > {1'b0, MAX_POS}) red_num = {1'b0, MAX_POS};
      if (red_den > {1'b0, MAX_POS}) red_den = {1'b0, MAX_POS};
      reduced.num_out        = negative ? -red_num[DATA_WIDTH-1:0] : red_num[DATA_WIDTH-1:0];
      reduced.den_out        = red_den[DATA_WIDTH-2:0];
      reduced.undefined_flag = 1'b0;
      return reduced;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      fraction_pair_type oldest;
      string src;
      if (!reset) begin
         if (req_valid && !req_stall)
            reduced_q.push_back('{fraction: req_data, reduced: reduce_fraction(req_data)});
         if (rsp_valid && !rsp_stall) begin
            if (reduced_q.size() == 0) begin
               report_mismatch($sformatf("result %0d/%0d arrived with nothing expected",
                                         $signed(rsp_data.num_out), rsp_data.den_out));
            end else begin
               oldest = reduced_q.pop_front();
               src = $sformatf("%0d/%0d", $signed(oldest.fraction.num_in),
                               $signed(oldest.fraction.den_in));
               if (rsp_data.num_out !== oldest.reduced.num_out)
                  report_mismatch($sformatf("%s: num_out %0d, expected %0d", src,
                                            $signed(rsp_data.num_out),
                                            $signed(oldest.reduced.num_out)));
               if (rsp_data.den_out !== oldest.reduced.den_out)
                  report_mismatch($sformatf("%s: den_out %0d, expected %0d", src,
                                            rsp_data.den_out, oldest.reduced.den_out));
               if (rsp_data.undefined_flag !== oldest.reduced.undefined_flag)
                  report_mismatch($sformatf("%s: undefined_flag %b, expected %b", src,
                                            rsp_data.undefined_flag,
                                            oldest.reduced.undefined_flag));
            end
         end
         pending = reduced_q.size();
      end
   end

endmodule

// ----- test/rational_normalizer_test.sv -----
// ----------------------------------------------------------------------------
// rational_normalizer_test
// Drives fractions into the rational normalizer: a directed set of signs,
// zeros and extreme magnitudes, then random fractions, about half of them built
// with a known common factor, under random gaps and result stalls.
// ----------------------------------------------------------------------------
module rational_normalizer_test
   import rnorm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT        = 500_000;
   localparam int RANDOM_ITEMS = 500;
   localparam int MAX_GAP      = 16;
   localparam int DRAIN        = 300;

   localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   rnorm_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rnorm_rsp_type rsp_data;

   int mismatches;
   int pending;
   int cycles = 0;
   bit steady = 1'b0;

   rational_normalizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rational_normalizer_checker fraction_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #4ns clock = 1'b1;
      #4ns clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] random_bits(int unsigned nbits);
      logic [63:0] raw = {$urandom, $urandom};
      logic [63:0] mask = (nbits >= 64) ? '1 : ((64'd1 << nbits) - 1);
      return DATA_WIDTH'(raw & mask);
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] with_sign(logic [DATA_WIDTH-1:0] mag);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance,
   // with valid still high so that a back-to-back item keeps it there.
   task automatic send_fraction(input logic signed [DATA_WIDTH-1:0] num,
                                input logic signed [DATA_WIDTH-1:0] den);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= '{num_in: num, den_in: den};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random_fraction();
      logic [DATA_WIDTH-1:0] num, den, factor;
      int unsigned fbits;
      case ($urandom_range(0, 9)) inside
         [0:1]: begin
            do num = random_bits(DATA_WIDTH); while (num == MOST_NEG);
            do den = random_bits(DATA_WIDTH); while (den == MOST_NEG);
            send_fraction(num, den);
         end
         [2:5]: begin
            // Both terms share a random factor, so the GCD does real work.
            fbits  = $urandom_range(1, 20);
            factor = random_bits(fbits) | 1;
            num    = random_bits($urandom_range(0, DATA_WIDTH - 1 - fbits)) * factor;
            den    = random_bits($urandom_range(0, DATA_WIDTH - 1 - fbits)) * factor;
            send_fraction(with_sign(num), with_sign(den));
         end
         6: send_fraction($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
         7: begin
            num = random_bits($urandom_range(1, DATA_WIDTH - 1));
            if ($urandom_range(0, 1)) send_fraction(with_sign(num), 0);
            else send_fraction(0, with_sign(num));
         end
         8: begin
            num = random_bits($urandom_range(1, 12)) << $urandom_range(0, 18);
            den = random_bits($urandom_range(1, 12)) << $urandom_range(0, 18);
            send_fraction(with_sign(num), with_sign(den));
         end
         default: begin
            // One term is a whole multiple of the other.
            num    = random_bits($urandom_range(1, 15)) | 1;
            factor = random_bits($urandom_range(1, 15));
            if ($urandom_range(0, 1)) send_fraction(with_sign(num), with_sign(num * factor));
            else send_fraction(with_sign(num * factor), with_sign(num));
         end
      endcase
   endtask

   // The result side holds stall for a random count, or none while steady is set, before taking each item.
   initial begin
      int stall_len;
      @(negedge clock);
      forever begin
         stall_len = draw_wait();
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_fraction(0, 0);
      send_fraction(0, 5);
      send_fraction(0, -5);
      send_fraction(7, 0);
      send_fraction(-7, 0);
      send_fraction(6, 4);
      send_fraction(-6, 4);
      send_fraction(6, -4);
      send_fraction(-6, -4);
      send_fraction(MAX_POS, MAX_POS);
      send_fraction(-MAX_POS, MAX_POS);
      send_fraction(MAX_POS, 1);
      send_fraction(-MAX_POS, -1);
      send_fraction(1, MAX_POS);
      send_fraction(MAX_POS, MAX_POS - 1);
      send_fraction(3 << 20, 5 << 20);
      // The most negative value keeps its exact magnitude and saturates
      // where the reduced result cannot hold it.
      send_fraction(MOST_NEG, 1);
      send_fraction(MOST_NEG, -1);
      send_fraction(1, MOST_NEG);
      send_fraction(MOST_NEG, MOST_NEG);
      send_fraction(MOST_NEG, 0);
      send_fraction(0, MOST_NEG);
      send_fraction(MOST_NEG, 6);
      send_fraction(32'h5555_5555, 32'h2AAA_AAAA);

      // Let the block empty before the random part.
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
         send_random_fraction();
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
